@@ rtl/core/wdc_pkg.sv @@
// ---------------------------------------------------------------------------
// wdc_pkg
// Shared field widths, item codes and control structs for the window
// distinct counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package wdc_pkg;

   localparam int POS_W = 12;   // load position field
   localparam int VAL_W = 12;   // compressed value field
   localparam int IDX_W = 13;   // window bounds and element count
   localparam int CNT_W = 13;   // occurrence counts and distinct total

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Request from the sequencer to the occurrence count unit.
   typedef struct packed {
      logic             valid;
      logic             remove;
      logic [VAL_W-1:0] value;
   } cnt_req_type;

   // Status returned by the occurrence count unit.
   typedef struct packed {
      logic             ready;
      logic [CNT_W-1:0] distinct;
   } cnt_stat_type;

endpackage

@@ rtl/core/wdc_if.sv @@
// ---------------------------------------------------------------------------
// wdc_req_if / wdc_rsp_if
// Valid/ready channels for load and query items and for query results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wdc_req_if
   import wdc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             kind;
   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] value;
   logic [IDX_W-1:0] range_left;
   logic [IDX_W-1:0] range_right;

   modport source (output valid, kind, position, value, range_left, range_right,
                   input ready);
   modport sink   (input valid, kind, position, value, range_left, range_right,
                   output ready);
endinterface

interface wdc_rsp_if
   import wdc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] distinct_count;
   logic             bad_range;

   modport source (output valid, distinct_count, bad_range, input ready);
   modport sink   (input valid, distinct_count, bad_range, output ready);
endinterface

@@ rtl/core/wdc_elem_store.sv @@
// ---------------------------------------------------------------------------
// wdc_elem_store
// Element store: one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdc_elem_store
   import wdc_pkg::*;
#(
   parameter int ARRAY_DEPTH = 4096
) (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic [$clog2(ARRAY_DEPTH)-1:0] rd_addr,
   output logic [VAL_W-1:0]               rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(ARRAY_DEPTH)-1:0] wr_addr,
   input  logic [VAL_W-1:0]               wr_data
);

   logic [VAL_W-1:0] mem [ARRAY_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/wdc_count_unit.sv @@
// ---------------------------------------------------------------------------
// wdc_count_unit
// Occurrence table with read-modify-write update and the distinct total.
// Sweeps the table to zero after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdc_count_unit
   import wdc_pkg::*;
#(
   parameter int VALUE_RANGE = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  cnt_req_type  cnt_req,
   output cnt_stat_type cnt_stat
);

   localparam int VW = $clog2(VALUE_RANGE);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_READY  = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [CNT_W-1:0] occ_mem [VALUE_RANGE];

   logic [1:0]       state_ff, state_in;
   logic [VW-1:0]    clr_addr_ff, clr_addr_in;
   logic [CNT_W-1:0] distinct_ff, distinct_in;
   logic [VW-1:0]    op_addr_ff, op_addr_in;
   logic             op_remove_ff, op_remove_in;
   logic             op_ok_ff, op_ok_in;
   logic [CNT_W-1:0] rd_data_ff;

   logic             rd_en;
   logic             wr_en;
   logic [VW-1:0]    wr_addr;
   logic [CNT_W-1:0] wr_data;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      distinct_in  = distinct_ff;
      op_addr_in   = op_addr_ff;
      op_remove_in = op_remove_ff;
      op_ok_in     = op_ok_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == VW'(VALUE_RANGE - 1)) begin
               state_in = ST_READY;
            end
         end
         ST_READY: begin
            if (cnt_req.valid) begin
               rd_en        = 1'b1;
               op_addr_in   = VW'(cnt_req.value);
               op_remove_in = cnt_req.remove;
               op_ok_in     = 32'(cnt_req.value) < VALUE_RANGE;
               state_in     = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            wr_addr  = op_addr_ff;
            state_in = ST_READY;
            if (op_ok_ff) begin
               if (!op_remove_ff) begin
                  wr_en   = 1'b1;
                  wr_data = rd_data_ff + 1'b1;
                  if (rd_data_ff == '0) begin
                     distinct_in = distinct_ff + 1'b1;
                  end
               end else if (rd_data_ff != '0) begin
                  // Removal from an empty count leaves everything alone.
                  wr_en   = 1'b1;
                  wr_data = rd_data_ff - 1'b1;
                  if (wr_data == '0 && distinct_ff != '0) begin
                     distinct_in = distinct_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         distinct_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         distinct_ff <= distinct_in;
      end
   end

   always_ff @(posedge clock) begin
      op_addr_ff   <= op_addr_in;
      op_remove_ff <= op_remove_in;
      op_ok_ff     <= op_ok_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         occ_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= occ_mem[op_addr_in];
      end
   end

   assign cnt_stat.ready    = (state_ff == ST_READY);
   assign cnt_stat.distinct = distinct_ff;

endmodule

@@ rtl/core/window_distinct_counter.sv @@
// ---------------------------------------------------------------------------
// window_distinct_counter
// Counts distinct values in a half-open window [left, right) of an element
// store, moving the window one element at a time between queries.
//
// Items arrive on req_ch. A load (kind = 0) writes one element; a query
// (kind = 1) moves the window to [range_left, range_right) and produces one
// transfer on rsp_ch with the distinct count. The user must write
// element_count (csr_we/csr_wdata) only while idle; the block does not check.
//
// Sequence: a load outside the window is written to the store directly; a
// load inside it also takes the old value out of the count and the new
// value in. A query moves its edges one element per step and is answered
// before the next item is taken; each element step is an element store read
// followed by an occurrence table read and write-back. An invalid query is
// answered with bad_range set and the window untouched.
//
// After reset the table is swept to zero with req_ch.ready low. A stalled
// receiver holds the result in its output register while loads are still
// taken; a query waits at its end until that result has been taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module window_distinct_counter
   import wdc_pkg::*;
#(
   parameter int ARRAY_DEPTH = 4096,
   parameter int VALUE_RANGE = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_wdata,
   wdc_req_if.sink          req_ch,
   wdc_rsp_if.source        rsp_ch
);

   localparam int AW = $clog2(ARRAY_DEPTH);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_STEP     = 3'd1;
   localparam logic [2:0] ST_VAL      = 3'd2;
   localparam logic [2:0] ST_LOAD_OLD = 3'd3;
   localparam logic [2:0] ST_LOAD_NEW = 3'd4;
   localparam logic [2:0] ST_RESP     = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] elem_count_ff, elem_count_in;
   logic [IDX_W-1:0] wl_ff, wl_in;          // current window, left edge
   logic [IDX_W-1:0] wr_ff, wr_in;          // current window, right edge
   logic [IDX_W-1:0] ql_ff, ql_in;          // target window of the query
   logic [IDX_W-1:0] qr_ff, qr_in;
   logic             remove_ff, remove_in;
   logic [POS_W-1:0] ld_pos_ff, ld_pos_in;
   logic [VAL_W-1:0] ld_val_ff, ld_val_in;
   logic             bad_ff, bad_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic             rsp_bad_ff, rsp_bad_in;

   logic             elem_rd_en;
   logic [AW-1:0]    elem_rd_addr;
   logic [VAL_W-1:0] elem_rd_data;
   logic             elem_wr_en;
   logic [AW-1:0]    elem_wr_addr;
   logic [VAL_W-1:0] elem_wr_data;

   cnt_req_type      cnt_req;
   cnt_stat_type     cnt_stat;

   logic             req_ready;
   logic             ld_ok;
   logic             ld_in_window;
   logic             query_bad;

   wdc_elem_store #(
      .ARRAY_DEPTH (ARRAY_DEPTH)
   ) u_elem_store (
      .clock   (clock),
      .rd_en   (elem_rd_en),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data)
   );

   wdc_count_unit #(
      .VALUE_RANGE (VALUE_RANGE)
   ) u_count_unit (
      .clock    (clock),
      .reset    (reset),
      .cnt_req  (cnt_req),
      .cnt_stat (cnt_stat)
   );

   // Loads out of range of the store or the table are dropped.
   assign ld_ok = (32'(req_ch.position) < ARRAY_DEPTH) &&
                  (32'(req_ch.value) < VALUE_RANGE);
   assign ld_in_window = ({1'b0, req_ch.position} >= wl_ff) &&
                         ({1'b0, req_ch.position} < wr_ff);
   assign query_bad = (req_ch.range_left > req_ch.range_right) ||
                      (req_ch.range_right > elem_count_ff) ||
                      (32'(req_ch.range_right) > ARRAY_DEPTH);

   always_comb begin
      state_in      = state_ff;
      elem_count_in = csr_we ? csr_wdata : elem_count_ff;
      wl_in         = wl_ff;
      wr_in         = wr_ff;
      ql_in         = ql_ff;
      qr_in         = qr_ff;
      remove_in     = remove_ff;
      ld_pos_in     = ld_pos_ff;
      ld_val_in     = ld_val_ff;
      bad_in        = bad_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_bad_in    = rsp_bad_ff;
      req_ready     = 1'b0;
      elem_rd_en    = 1'b0;
      elem_rd_addr  = '0;
      elem_wr_en    = 1'b0;
      elem_wr_addr  = AW'(ld_pos_ff);
      elem_wr_data  = ld_val_ff;
      cnt_req       = '0;

      // A waiting result leaves the output register once it is taken.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = cnt_stat.ready;
            if (req_ch.valid && cnt_stat.ready) begin
               if (req_ch.kind == KIND_LOAD) begin
                  ld_pos_in = req_ch.position;
                  ld_val_in = req_ch.value;
                  if (ld_ok) begin
                     if (ld_in_window) begin
                        // Fetch the old value so it can be counted out.
                        elem_rd_en   = 1'b1;
                        elem_rd_addr = AW'(req_ch.position);
                        state_in     = ST_LOAD_OLD;
                     end else begin
                        elem_wr_en   = 1'b1;
                        elem_wr_addr = AW'(req_ch.position);
                        elem_wr_data = req_ch.value;
                     end
                  end
               end else begin
                  bad_in = query_bad;
                  ql_in  = req_ch.range_left;
                  qr_in  = req_ch.range_right;
                  state_in = query_bad ? ST_RESP : ST_STEP;
               end
            end
         end
         ST_STEP: begin
            // One edge moves by one element per step: grow left, grow right,
            // shrink left, shrink right, in that order of priority.
            priority if (wl_ff > ql_ff) begin
               wl_in        = wl_ff - 1'b1;
               elem_rd_en   = 1'b1;
               elem_rd_addr = AW'(wl_in);
               remove_in    = 1'b0;
               state_in     = ST_VAL;
            end else if (wr_ff < qr_ff) begin
               wr_in        = wr_ff + 1'b1;
               elem_rd_en   = 1'b1;
               elem_rd_addr = AW'(wr_ff);
               remove_in    = 1'b0;
               state_in     = ST_VAL;
            end else if (wl_ff < ql_ff) begin
               wl_in        = wl_ff + 1'b1;
               elem_rd_en   = 1'b1;
               elem_rd_addr = AW'(wl_ff);
               remove_in    = 1'b1;
               state_in     = ST_VAL;
            end else if (wr_ff > qr_ff) begin
               wr_in        = wr_ff - 1'b1;
               elem_rd_en   = 1'b1;
               elem_rd_addr = AW'(wr_in);
               remove_in    = 1'b1;
               state_in     = ST_VAL;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_VAL: begin
            if (cnt_stat.ready) begin
               cnt_req.valid  = 1'b1;
               cnt_req.remove = remove_ff;
               cnt_req.value  = elem_rd_data;
               state_in       = ST_STEP;
            end
         end
         ST_LOAD_OLD: begin
            if (cnt_stat.ready) begin
               cnt_req.valid  = 1'b1;
               cnt_req.remove = 1'b1;
               cnt_req.value  = elem_rd_data;
               state_in       = ST_LOAD_NEW;
            end
         end
         ST_LOAD_NEW: begin
            if (cnt_stat.ready) begin
               cnt_req.valid  = 1'b1;
               cnt_req.remove = 1'b0;
               cnt_req.value  = ld_val_ff;
               elem_wr_en     = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_RESP: begin
            // Wait for the last table update and for a free output register.
            if (cnt_stat.ready && (!rsp_valid_ff || rsp_ch.ready)) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = bad_ff ? '0 : cnt_stat.distinct;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         elem_count_ff <= '0;
         wl_ff         <= '0;
         wr_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         elem_count_ff <= elem_count_in;
         wl_ff         <= wl_in;
         wr_ff         <= wr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ql_ff        <= ql_in;
      qr_ff        <= qr_in;
      remove_ff    <= remove_in;
      ld_pos_ff    <= ld_pos_in;
      ld_val_ff    <= ld_val_in;
      bad_ff       <= bad_in;
      rsp_count_ff <= rsp_count_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign req_ch.ready          = req_ready;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.distinct_count = rsp_count_ff;
   assign rsp_ch.bad_range      = rsp_bad_ff;

endmodule

@@ rtl/core/wdc_checker.sv @@
// ---------------------------------------------------------------------------
// wdc_checker
// Port-level checks for the window distinct counter, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module wdc_checker
   import wdc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_kind,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [CNT_W-1:0] rsp_count,
   input logic             rsp_bad
);

   // A stalled result holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_bad))
      else $error("result changed while stalled");

   // An invalid query always reports a zero count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad |-> rsp_count == '0)
      else $error("bad_range with nonzero count");

   // A query transfer occupies the block for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == KIND_QUERY |=> !req_ready)
      else $error("input taken right after a query");

   // The table sweep after reset blocks input.
   assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input ready during table sweep");

endmodule

bind window_distinct_counter wdc_checker u_wdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_kind  (req_ch.kind),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_count (rsp_ch.distinct_count),
   .rsp_bad   (rsp_ch.bad_range)
);

@@ tb/distinct_count_checker.sv @@
// ---------------------------------------------------------------------------
// distinct_count_checker
// Watches the request, result and register ports of the window distinct
// counter, keeps its own copy of the element store, the occurrence table and
// the window, and compares every result transfer with the predicted answer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module distinct_count_checker
   import wdc_pkg::*;
#(
   parameter int ARRAY_DEPTH = 4096,
   parameter int VALUE_RANGE = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_wdata,
   wdc_req_if               req_mon,
   wdc_rsp_if               rsp_mon,
   output int               failures,
   output int               pending
);

   typedef struct packed {
      logic [CNT_W-1:0] distinct_count;
      logic             bad_range;
   } answer_type;

   answer_type       answers_due[$];
   logic [VAL_W-1:0] element_mem [ARRAY_DEPTH];
   logic [CNT_W-1:0] value_hits  [VALUE_RANGE];
   logic [CNT_W-1:0] live_values;
   logic [IDX_W-1:0] elem_limit;
   logic [IDX_W-1:0] win_lo;
   logic [IDX_W-1:0] win_hi;

   function automatic void admit(input logic [VAL_W-1:0] v);
      if (value_hits[v] == '0) live_values = live_values + 1'b1;
      value_hits[v] = value_hits[v] + 1'b1;
   endfunction

   // A count that is already zero stays there and leaves the total alone.
   function automatic void evict(input logic [VAL_W-1:0] v);
      if (value_hits[v] != '0) begin
         value_hits[v] = value_hits[v] - 1'b1;
         if (value_hits[v] == '0 && live_values != '0) live_values = live_values - 1'b1;
      end
   endfunction

   function automatic void apply_load(input logic [POS_W-1:0] pos,
                                      input logic [VAL_W-1:0] val);
      if (pos >= win_lo && pos < win_hi) begin
         evict(element_mem[pos]);
         admit(val);
      end
      element_mem[pos] = val;
   endfunction

   // Edges move in a fixed order: grow left, grow right, shrink left, shrink right.
   function automatic answer_type run_query(input logic [IDX_W-1:0] lo,
                                            input logic [IDX_W-1:0] hi);
      answer_type ans;
      ans.distinct_count = '0;
      ans.bad_range      = 1'b1;
      if (lo > hi || hi > elem_limit || hi > ARRAY_DEPTH) return ans;
      while (win_lo > lo) begin
         win_lo = win_lo - 1'b1;
         admit(element_mem[win_lo]);
      end
      while (win_hi < hi) begin
         admit(element_mem[win_hi]);
         win_hi = win_hi + 1'b1;
      end
      while (win_lo < lo) begin
         evict(element_mem[win_lo]);
         win_lo = win_lo + 1'b1;
      end
      while (win_hi > hi) begin
         win_hi = win_hi - 1'b1;
         evict(element_mem[win_hi]);
      end
      ans.distinct_count = live_values;
      ans.bad_range      = 1'b0;
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      answer_type due;
      if (reset) begin
         for (int i = 0; i < ARRAY_DEPTH; i++) element_mem[i] = '0;
         for (int i = 0; i < VALUE_RANGE; i++) value_hits[i] = '0;
         live_values = '0;
         elem_limit  = '0;
         win_lo      = '0;
         win_hi      = '0;
         answers_due.delete();
      end else begin
         if (csr_we) elem_limit = csr_wdata;
         // Results are handled before requests: a result leaving at this edge
         // always belongs to a query accepted at an earlier edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (answers_due.size() == 0) begin
               $error("unexpected result: distinct_count %0d bad_range %0b",
                      rsp_mon.distinct_count, rsp_mon.bad_range);
               failures++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_mon.distinct_count !== due.distinct_count) begin
                  $error("distinct_count: expected %0d, actual %0d",
                         due.distinct_count, rsp_mon.distinct_count);
                  failures++;
               end
               if (rsp_mon.bad_range !== due.bad_range) begin
                  $error("bad_range: expected %0b, actual %0b",
                         due.bad_range, rsp_mon.bad_range);
                  failures++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == KIND_LOAD)
               apply_load(req_mon.position, req_mon.value);
            else
               answers_due.push_back(run_query(req_mon.range_left, req_mon.range_right));
         end
      end
      pending = answers_due.size();
   end

endmodule

@@ tb/tb_window_distinct_counter.sv @@
// ---------------------------------------------------------------------------
// tb_window_distinct_counter
// Drives loads, range queries and element_count writes into the window
// distinct counter, with random idle cycles on both channels, and leaves the
// prediction and comparison of every result to distinct_count_checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_window_distinct_counter;
   import wdc_pkg::*;

   localparam int ARRAY_DEPTH = 4096;
   localparam int VALUE_RANGE = 4096;
   localparam int POS_MAX     = (1 << POS_W) - 1;
   localparam int VAL_MAX     = (1 << VAL_W) - 1;
   localparam int IDX_MAX     = (1 << IDX_W) - 1;
   // The slowest single query walks both edges across the whole store, about
   // 2 x 4096 element steps; the reset sweep clears all 4096 table entries.
   // The watchdog limit is well above the time either of these takes.
   localparam int QUIET_LIMIT = 100000;
   // The load that replaces a value inside the window must finish before a
   // register write; DRAIN_CYCLES leaves room for it.
   localparam int DRAIN_CYCLES = 8;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [IDX_W-1:0] csr_wdata;

   wdc_req_if req_ch ();
   wdc_rsp_if rsp_ch ();

   int pending_answers;
   int check_failures;
   int quiet_cycles;

   // The element_count most recently written, and which positions hold a
   // loaded element. A query may only pull in loaded positions, so every
   // position below element_count is loaded before queries run against it.
   int elem_limit;
   bit loaded [ARRAY_DEPTH];

   // While a calm flag is set, that side does not idle at all. The flags
   // flip now and then, which gives stretches with and without idle cycles.
   bit calm_tx;
   bit calm_rx;

   always #6 clock = ~clock;

   window_distinct_counter DUT (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

   distinct_count_checker #(
      .ARRAY_DEPTH(ARRAY_DEPTH),
      .VALUE_RANGE(VALUE_RANGE)
   ) count_check (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_mon  (req_ch),
      .rsp_mon  (rsp_ch),
      .failures (check_failures),
      .pending  (pending_answers)
   );

   function automatic int pause_len(input bit calm);
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   // Most values come from a small pool so that repeats are common and the
   // distinct count moves in both directions; the rest span the full field.
   function automatic int pick_value(input int vmax);
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, vmax);
      return $urandom_range(0, VAL_MAX);
   endfunction

   // One request transfer. Valid is only lowered when an idle gap is drawn,
   // so back-to-back items keep valid high without a glitch in the same step.
   task automatic send_request(input logic             kind,
                               input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val,
                               input logic [IDX_W-1:0] lo,
                               input logic [IDX_W-1:0] hi);
      int gap;
      if ($urandom_range(0, 31) == 0) calm_tx = !calm_tx;
      gap = pause_len(calm_tx);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= kind;
      req_ch.position    <= pos;
      req_ch.value       <= val;
      req_ch.range_left  <= lo;
      req_ch.range_right <= hi;
      do @(posedge clock); while (!req_ch.ready);
      if (kind == KIND_LOAD) loaded[pos] = 1'b1;
   endtask

   // The fields that an item kind does not use still carry random bits.
   task automatic load_element(input int pos, input int val);
      send_request(KIND_LOAD, POS_W'(pos), VAL_W'(val),
                   IDX_W'($urandom_range(0, IDX_MAX)),
                   IDX_W'($urandom_range(0, IDX_MAX)));
   endtask

   task automatic query_range(input int lo, input int hi);
      send_request(KIND_QUERY, POS_W'($urandom_range(0, POS_MAX)),
                   VAL_W'($urandom_range(0, VAL_MAX)), IDX_W'(lo), IDX_W'(hi));
   endtask

   // A query that must be refused: either the left edge lies past the right
   // one, or the right edge lies past element_count.
   task automatic query_bad();
      int lo;
      int hi;
      if ($urandom_range(0, 1) == 1) begin
         lo = $urandom_range(1, IDX_MAX);
         hi = $urandom_range(0, lo - 1);
      end else begin
         hi = $urandom_range(elem_limit + 1, IDX_MAX);
         lo = $urandom_range(0, IDX_MAX);
      end
      query_range(lo, hi);
   endtask

   // Waits until every query answer has come back and the block has had time
   // to finish a trailing load. The checker updates its count at the rising
   // edge, so the count is read at the falling edge to stay clear of it.
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_answers != 0);
      @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_element_count(input int n);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= IDX_W'(n);
      @(posedge clock);
      csr_we    <= 1'b0;
      elem_limit = n;
   endtask

   task automatic fill_missing(input int limit, input int vmax);
      int p;
      for (p = 0; p < limit; p++)
         if (!loaded[p]) load_element(p, pick_value(vmax));
   endtask

   // Mostly well-formed traffic: loads inside the counted region (which also
   // rewrite elements inside the current window), valid queries anywhere in
   // [0, element_count], and a share of refused queries. Some loads go to any
   // position of the store, beyond element_count as well.
   task automatic random_items(input int n_items, input int vmax);
      int pick;
      int pos;
      int lo;
      int hi;
      repeat (n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            if (elem_limit > 0 && $urandom_range(0, 6) != 0)
               pos = $urandom_range(0, elem_limit - 1);
            else
               pos = $urandom_range(0, POS_MAX);
            load_element(pos, pick_value(vmax));
         end else if (pick < 88) begin
            hi = $urandom_range(0, elem_limit);
            lo = $urandom_range(0, hi);
            query_range(lo, hi);
         end else begin
            query_bad();
         end
      end
   endtask

   task automatic random_phase(input int limit, input int n_items, input int vmax);
      set_element_count(limit);
      fill_missing(limit, vmax);
      random_items(n_items, vmax);
   endtask

   // The result side: for every result it draws a stall, holds ready low for
   // that many cycles, then keeps ready high until a transfer happens.
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) calm_rx = !calm_rx;
         stall = pause_len(calm_rx);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // Watchdog: any transfer on either channel restarts the count. Running out
   // means the block hung or an answer never came.
   initial begin : watchdog
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_LOAD;
      req_ch.position    = '0;
      req_ch.value       = '0;
      req_ch.range_left  = '0;
      req_ch.range_right = '0;
      elem_limit         = 0;
      calm_tx            = 1'b0;
      calm_rx            = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset element_count is zero: the empty window at the
      // origin is the only valid query. The first transfer also waits out
      // the table sweep that follows reset.
      query_range(0, 0);
      query_range(0, 1);
      query_range(1, 0);
      query_range(IDX_MAX, IDX_MAX);
      load_element(POS_MAX, VAL_MAX);
      load_element(0, 0);

      // A small store with repeated values at both ends of the value field.
      set_element_count(8);
      load_element(1, VAL_MAX);
      load_element(2, 0);
      load_element(3, 7);
      load_element(4, VAL_MAX);
      load_element(5, 7);
      load_element(6, 1);
      load_element(7, 0);
      query_range(0, 8);
      query_range(8, 8);
      query_range(7, 8);
      query_range(0, 8);
      // This position is inside the window, so the old value leaves the
      // count and the new one enters it.
      load_element(3, VAL_MAX);
      query_range(2, 6);
      // Loads beyond element_count are accepted; queries there are refused.
      load_element(8, 9);
      query_range(0, 9);
      query_range(9, 9);
      query_range(6, 2);
      query_range(0, 8);

      // Random traffic over several register settings, small stores mostly.
      random_phase(1, 120, 3);
      random_phase(64, 300, 15);
      random_phase(37, 250, VAL_MAX);
      random_phase(250, 150, 31);
      random_phase(8, 275, 7);

      // element_count at the full store depth: a right edge past the store
      // and a crossed pair of edges are both refused.
      set_element_count(ARRAY_DEPTH);
      query_range(0, ARRAY_DEPTH + 1);
      query_range(ARRAY_DEPTH, ARRAY_DEPTH - 1);
      query_bad();
      query_bad();

      // Back to an element_count of zero: the window collapses to the origin.
      set_element_count(0);
      query_range(0, 0);
      random_items(40, 15);

      settle();
      if (check_failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
